FILE: hw/rtl/vbc_pkg.sv
// Shared constants, types and helper functions of the voxel box counting core.
// Used by vbc_store, vbc_walker and voxel_box_counting_core; depends on nothing.
`default_nettype none

package vbc_pkg;

   localparam int SIDE_MAX = 64;
   localparam int COORD_W  = $clog2(SIDE_MAX);
   localparam int ADDR_W   = 3 * COORD_W;
   localparam int DEPTH    = 1 << ADDR_W;
   localparam int LEVELS   = COORD_W + 1;

   localparam int DIM_W    = 7;
   localparam int LABEL_W  = 2;
   localparam int PHASE_W  = 2;
   localparam int EXP_W    = 3;
   localparam int COUNT_W  = 19;
   localparam int PHASES   = 3;
   localparam int CHILD_W  = 3;
   localparam int IDX_W    = 2;

   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 24;
   localparam int RSP_USER_W = PHASE_W + EXP_W;

   localparam logic [IDX_W-1:0] REG_ROWS    = 2'd0;
   localparam logic [IDX_W-1:0] REG_COLUMNS = 2'd1;
   localparam logic [IDX_W-1:0] REG_SLICES  = 2'd2;

   localparam logic [LABEL_W-1:0] LABEL_NONE = 2'd3;

   localparam logic [PHASE_W-1:0] PHASE_PORE = 2'd0;
   localparam logic [PHASE_W-1:0] PHASE_BULK = 2'd2;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_REDUCE,
      ST_DRAIN,
      ST_WAIT
   } walk_state_type;

   typedef struct packed {
      logic [DIM_W-1:0] rows;
      logic [DIM_W-1:0] columns;
      logic [DIM_W-1:0] slices;
      logic [EXP_W-1:0] pad_exp;
   } geom_type;

   typedef struct packed {
      logic              valid;
      logic [EXP_W-1:0]  level;
      logic [PHASES-1:0] hits;
   } count_evt_type;

   // Zero reads as one, anything above the largest side reads as that side.
   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
      logic [DIM_W-1:0] r;
      r = v;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if (v > DIM_W'(SIDE_MAX)) begin
         r = DIM_W'(SIDE_MAX);
      end
      return r;
   endfunction

   // Smallest e with 2^e at least the largest dimension.
   function automatic logic [EXP_W-1:0] pad_exponent(input logic [DIM_W-1:0] a,
                                                     input logic [DIM_W-1:0] b,
                                                     input logic [DIM_W-1:0] c);
      logic [DIM_W-1:0] m;
      logic [EXP_W-1:0] e;
      m = a;
      e = '0;
      if (b > m) begin
         m = b;
      end
      if (c > m) begin
         m = c;
      end
      for (int i = 0; i < COORD_W; i++) begin
         if ((DIM_W'(1) << i) < m) begin
            e = EXP_W'(i + 1);
         end
      end
      return e;
   endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/voxel_box_counting_core.sv
// Voxel box counting core: volume dimensions are set through the csr port, then
// one voxel label is taken per cycle in raster order (rows fastest, then columns,
// then slices). The volume is padded to a cube of side P = 2^E, E the smallest
// exponent with P at least the largest dimension. After the final voxel the store
// is reduced in place, one level per box side 2^e for e = 1..E; each box reads
// its eight children through the single read port of the store, and no request
// is taken meanwhile. Then 3*(E+1) results follow, phase by phase with the
// exponent rising, one per cycle while rsp_tready is high; the next volume may
// begin loading while the final result waits. The store needs no clearing pass:
// padding outside the volume reads as empty, so volumes follow back to back.
// A write to the rows, columns or slices register drops any partly loaded volume.
// Uses vbc_pkg.
`default_nettype none

module voxel_box_counting_core (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   input  wire logic [vbc_pkg::REQ_DATA_W-1:0] req_tdata,  // [1:0] voxel_label
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   output logic      [vbc_pkg::RSP_DATA_W-1:0] rsp_tdata,  // [18:0] box_count
   output logic      [vbc_pkg::RSP_USER_W-1:0] rsp_tuser,  // [1:0] phase, [4:2] scale_exponent
   output logic                                rsp_tlast,  // last_result
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [vbc_pkg::IDX_W-1:0]      csr_index,
   input  wire logic [vbc_pkg::DIM_W-1:0]      csr_data
);

   logic [vbc_pkg::DIM_W-1:0]   rows_ff, rows_in, cols_ff, cols_in, slices_ff, slices_in;
   logic                        cfg_clear;
   vbc_pkg::geom_type           geom;

   logic                        reduce_done, emit_done;
   vbc_pkg::count_evt_type      count_evt;
   logic                        st_wr_en, st_rd_en;
   logic [vbc_pkg::ADDR_W-1:0]  st_wr_addr, st_rd_addr;
   logic [vbc_pkg::PHASES-1:0]  st_wr_data, st_rd_data;

   logic [vbc_pkg::COUNT_W-1:0] cnt_ff [vbc_pkg::PHASES][vbc_pkg::LEVELS];

   logic                        emit_active_ff, emit_active_in;
   logic [vbc_pkg::PHASE_W-1:0] ph_ff, ph_in;
   logic [vbc_pkg::EXP_W-1:0]   ex_ff, ex_in;
   logic                        load_rsp, is_last;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [vbc_pkg::COUNT_W-1:0] rsp_count_ff;
   logic [vbc_pkg::PHASE_W-1:0] rsp_phase_ff;
   logic [vbc_pkg::EXP_W-1:0]   rsp_exp_ff;
   logic                        rsp_last_ff;

   // Configuration registers, held clamped to the legal range.
   assign csr_ready = 1'b1;
   assign cfg_clear = csr_valid && (csr_index inside {vbc_pkg::REG_ROWS,
                                                      vbc_pkg::REG_COLUMNS,
                                                      vbc_pkg::REG_SLICES});

   always_comb begin
      rows_in   = rows_ff;
      cols_in   = cols_ff;
      slices_in = slices_ff;
      if (csr_valid) begin
         case (csr_index)
            vbc_pkg::REG_ROWS:    rows_in   = vbc_pkg::clamp_dim(csr_data);
            vbc_pkg::REG_COLUMNS: cols_in   = vbc_pkg::clamp_dim(csr_data);
            vbc_pkg::REG_SLICES:  slices_in = vbc_pkg::clamp_dim(csr_data);
            default:              rows_in   = rows_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff   <= vbc_pkg::DIM_W'(vbc_pkg::SIDE_MAX);
         cols_ff   <= vbc_pkg::DIM_W'(vbc_pkg::SIDE_MAX);
         slices_ff <= vbc_pkg::DIM_W'(vbc_pkg::SIDE_MAX);
      end else begin
         rows_ff   <= rows_in;
         cols_ff   <= cols_in;
         slices_ff <= slices_in;
      end
   end

   assign geom.rows    = rows_ff;
   assign geom.columns = cols_ff;
   assign geom.slices  = slices_ff;
   assign geom.pad_exp = vbc_pkg::pad_exponent(rows_ff, cols_ff, slices_ff);

   vbc_walker u_walker (
      .clock       (clock),
      .reset       (reset),
      .cfg_clear   (cfg_clear),
      .geom        (geom),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_label   (req_tdata[vbc_pkg::LABEL_W-1:0]),
      .emit_done   (emit_done),
      .reduce_done (reduce_done),
      .count_evt   (count_evt),
      .st_wr_en    (st_wr_en),
      .st_wr_addr  (st_wr_addr),
      .st_wr_data  (st_wr_data),
      .st_rd_en    (st_rd_en),
      .st_rd_addr  (st_rd_addr),
      .st_rd_data  (st_rd_data)
   );

   vbc_store u_store (
      .clock   (clock),
      .wr_en   (st_wr_en),
      .wr_addr (st_wr_addr),
      .wr_data (st_wr_data),
      .rd_en   (st_rd_en),
      .rd_addr (st_rd_addr),
      .rd_data (st_rd_data)
   );

   // Result sequencing: phase outer, exponent inner.
   assign load_rsp = emit_active_ff && (!rsp_valid_ff || rsp_tready);
   assign is_last  = (ph_ff == vbc_pkg::PHASE_BULK) && (ex_ff == geom.pad_exp);
   assign emit_done = load_rsp && is_last;

   always_comb begin
      emit_active_in = emit_active_ff;
      ph_in          = ph_ff;
      ex_in          = ex_ff;
      if (reduce_done) begin
         emit_active_in = 1'b1;
         ph_in          = vbc_pkg::PHASE_PORE;
         ex_in          = '0;
      end else if (load_rsp) begin
         if (ex_ff == geom.pad_exp) begin
            ex_in = '0;
            ph_in = ph_ff + vbc_pkg::PHASE_W'(1);
         end else begin
            ex_in = ex_ff + vbc_pkg::EXP_W'(1);
         end
         if (is_last) begin
            emit_active_in = 1'b0;
         end
      end
      if (cfg_clear) begin
         emit_active_in = 1'b0;
      end
   end

   assign rsp_valid_in = load_rsp ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         emit_active_ff <= 1'b0;
         ph_ff          <= vbc_pkg::PHASE_PORE;
         ex_ff          <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         emit_active_ff <= emit_active_in;
         ph_ff          <= ph_in;
         ex_ff          <= ex_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_count_ff <= cnt_ff[ph_ff][ex_ff];
         rsp_phase_ff <= ph_ff;
         rsp_exp_ff   <= ex_ff;
         rsp_last_ff  <= is_last;
      end
   end

   // Box totals per phase and level; drop them once the volume is reported.
   always_ff @(posedge clock) begin
      if (reset || cfg_clear || emit_done) begin
         for (int p = 0; p < vbc_pkg::PHASES; p++) begin
            for (int l = 0; l < vbc_pkg::LEVELS; l++) begin
               cnt_ff[p][l] <= '0;
            end
         end
      end else if (count_evt.valid) begin
         for (int p = 0; p < vbc_pkg::PHASES; p++) begin
            cnt_ff[p][count_evt.level] <= cnt_ff[p][count_evt.level]
                                          + vbc_pkg::COUNT_W'(count_evt.hits[p]);
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = vbc_pkg::RSP_DATA_W'(rsp_count_ff);
   assign rsp_tuser  = {rsp_exp_ff, rsp_phase_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/vbc_store.sv
// Occupancy store: one 3-bit phase mask per voxel of the padded cube.
// Single write port, single read port with a registered read; uses vbc_pkg.
`default_nettype none

module vbc_store (
   input  wire logic                       clock,
   input  wire logic                       wr_en,
   input  wire logic [vbc_pkg::ADDR_W-1:0] wr_addr,
   input  wire logic [vbc_pkg::PHASES-1:0] wr_data,
   input  wire logic                       rd_en,
   input  wire logic [vbc_pkg::ADDR_W-1:0] rd_addr,
   output logic      [vbc_pkg::PHASES-1:0] rd_data
);

   logic [vbc_pkg::PHASES-1:0] mem [vbc_pkg::DEPTH];
   logic [vbc_pkg::PHASES-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/vbc_walker.sv
// Load and reduction sequencer: writes voxels into the store, then walks each
// level reading eight children per box and writing the OR back. Uses vbc_pkg.
`default_nettype none

module vbc_walker (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        cfg_clear,
   input  wire vbc_pkg::geom_type           geom,
   input  wire logic                        req_tvalid,
   output logic                             req_tready,
   input  wire logic [vbc_pkg::LABEL_W-1:0] req_label,
   input  wire logic                        emit_done,
   output logic                             reduce_done,
   output vbc_pkg::count_evt_type           count_evt,
   output logic                             st_wr_en,
   output logic      [vbc_pkg::ADDR_W-1:0]  st_wr_addr,
   output logic      [vbc_pkg::PHASES-1:0]  st_wr_data,
   output logic                             st_rd_en,
   output logic      [vbc_pkg::ADDR_W-1:0]  st_rd_addr,
   input  wire logic [vbc_pkg::PHASES-1:0]  st_rd_data
);

   localparam int CW = vbc_pkg::COORD_W;
   localparam int DW = vbc_pkg::DIM_W;

   vbc_pkg::walk_state_type state_ff, state_in;

   logic [CW-1:0]               ci_ff, ci_in, cj_ff, cj_in, ck_ff, ck_in;
   logic [vbc_pkg::CHILD_W-1:0] child_ff, child_in;
   logic [vbc_pkg::EXP_W-1:0]   level_ff, level_in;
   logic [vbc_pkg::PHASES-1:0]  acc_ff, acc_in;

   logic                        rd_valid_ff, rd_valid_in;
   logic                        rd_mask_ff, rd_first_ff, rd_last_ff;
   logic [vbc_pkg::ADDR_W-1:0]  rd_origin_ff;
   logic [vbc_pkg::EXP_W-1:0]   rd_level_ff;

   logic                        fire, issue;
   logic                        row_end, col_end, slice_end, load_last;
   logic [DW-1:0]               side, step, ni, nj, nk;
   logic [CW-1:0]               half, cx, cy, cz;
   logic                        i_wrap, j_wrap, k_wrap, level_last, box_last;
   logic                        in_vol, mask;
   logic [vbc_pkg::PHASES-1:0]  label_hits, merged;

   assign fire      = req_tvalid && req_tready;
   assign row_end   = {1'b0, ci_ff} == geom.rows - DW'(1);
   assign col_end   = {1'b0, cj_ff} == geom.columns - DW'(1);
   assign slice_end = {1'b0, ck_ff} == geom.slices - DW'(1);
   assign load_last = row_end && col_end && slice_end;

   assign label_hits = (req_label == vbc_pkg::LABEL_NONE) ? '0
                       : vbc_pkg::PHASES'(1) << req_label;

   // Box geometry of the current level: side, child offset, origin step.
   assign side = DW'(1) << geom.pad_exp;
   assign step = DW'(1) << level_ff;
   assign half = CW'(step >> 1);
   assign cx   = ci_ff + (child_ff[0] ? half : '0);
   assign cy   = cj_ff + (child_ff[1] ? half : '0);
   assign cz   = ck_ff + (child_ff[2] ? half : '0);
   assign ni   = {1'b0, ci_ff} + step;
   assign nj   = {1'b0, cj_ff} + step;
   assign nk   = {1'b0, ck_ff} + step;
   assign i_wrap     = ni == side;
   assign j_wrap     = nj == side;
   assign k_wrap     = nk == side;
   assign level_last = i_wrap && j_wrap && k_wrap;
   assign box_last   = &child_ff;

   // First level reads raw voxels: padding outside the volume reads as empty.
   assign in_vol = ({1'b0, cx} < geom.rows) && ({1'b0, cy} < geom.columns)
                   && ({1'b0, cz} < geom.slices);
   assign mask   = (level_ff != vbc_pkg::EXP_W'(1)) || in_vol;

   assign merged = (rd_first_ff ? '0 : acc_ff) | (rd_mask_ff ? st_rd_data : '0);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         vbc_pkg::ST_LOAD: begin
            if (fire && load_last) begin
               state_in = (geom.pad_exp == '0) ? vbc_pkg::ST_WAIT : vbc_pkg::ST_REDUCE;
            end
         end
         vbc_pkg::ST_REDUCE: begin
            if (box_last && level_last) begin
               state_in = vbc_pkg::ST_DRAIN;
            end
         end
         vbc_pkg::ST_DRAIN: begin
            state_in = (level_ff == geom.pad_exp) ? vbc_pkg::ST_WAIT : vbc_pkg::ST_REDUCE;
         end
         vbc_pkg::ST_WAIT: begin
            if (emit_done) begin
               state_in = vbc_pkg::ST_LOAD;
            end
         end
         default: state_in = vbc_pkg::ST_LOAD;
      endcase
      if (cfg_clear) begin
         state_in = vbc_pkg::ST_LOAD;
      end
   end

   // State outputs; ready is always high while loading.
   always_comb begin
      req_tready  = 1'b0;
      issue       = 1'b0;
      reduce_done = 1'b0;
      case (state_ff)
         vbc_pkg::ST_LOAD: begin
            req_tready  = 1'b1;
            reduce_done = req_tvalid && load_last && (geom.pad_exp == '0);
         end
         vbc_pkg::ST_REDUCE: begin
            issue = 1'b1;
         end
         vbc_pkg::ST_DRAIN: begin
            reduce_done = level_ff == geom.pad_exp;
         end
         vbc_pkg::ST_WAIT: begin
            reduce_done = 1'b0;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   // Coordinates, child index and level
   always_comb begin
      ci_in    = ci_ff;
      cj_in    = cj_ff;
      ck_in    = ck_ff;
      child_in = child_ff;
      level_in = level_ff;
      if (fire) begin
         level_in = vbc_pkg::EXP_W'(1);
         if (!row_end) begin
            ci_in = ci_ff + CW'(1);
         end else begin
            ci_in = '0;
            if (!col_end) begin
               cj_in = cj_ff + CW'(1);
            end else begin
               cj_in = '0;
               ck_in = slice_end ? '0 : ck_ff + CW'(1);
            end
         end
      end else if (issue) begin
         child_in = child_ff + vbc_pkg::CHILD_W'(1);
         if (box_last) begin
            if (!i_wrap) begin
               ci_in = CW'(ni);
            end else begin
               ci_in = '0;
               if (!j_wrap) begin
                  cj_in = CW'(nj);
               end else begin
                  cj_in = '0;
                  ck_in = k_wrap ? '0 : CW'(nk);
               end
            end
         end
      end else if (state_ff == vbc_pkg::ST_DRAIN) begin
         level_in = level_ff + vbc_pkg::EXP_W'(1);
      end
      if (cfg_clear) begin
         ci_in    = '0;
         cj_in    = '0;
         ck_in    = '0;
         child_in = '0;
      end
   end

   assign rd_valid_in = issue && !cfg_clear;
   assign acc_in      = rd_valid_ff ? merged : acc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= vbc_pkg::ST_LOAD;
         ci_ff       <= '0;
         cj_ff       <= '0;
         ck_ff       <= '0;
         child_ff    <= '0;
         level_ff    <= vbc_pkg::EXP_W'(1);
         rd_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         ci_ff       <= ci_in;
         cj_ff       <= cj_in;
         ck_ff       <= ck_in;
         child_ff    <= child_in;
         level_ff    <= level_in;
         rd_valid_ff <= rd_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff       <= acc_in;
      rd_mask_ff   <= mask;
      rd_first_ff  <= child_ff == '0;
      rd_last_ff   <= box_last;
      rd_origin_ff <= {ck_ff, cj_ff, ci_ff};
      rd_level_ff  <= level_ff;
   end

   assign st_rd_en   = issue;
   assign st_rd_addr = {cz, cy, cx};

   // Load writes voxels; reduction writes the merged box back at its origin.
   always_comb begin
      if (state_ff == vbc_pkg::ST_LOAD) begin
         st_wr_en        = fire;
         st_wr_addr      = {ck_ff, cj_ff, ci_ff};
         st_wr_data      = label_hits;
         count_evt.valid = fire;
         count_evt.level = '0;
         count_evt.hits  = label_hits;
      end else begin
         st_wr_en        = rd_valid_ff && rd_last_ff;
         st_wr_addr      = rd_origin_ff;
         st_wr_data      = merged;
         count_evt.valid = rd_valid_ff && rd_last_ff;
         count_evt.level = rd_level_ff;
         count_evt.hits  = merged;
      end
   end

   a_no_read_in_load : assert property (@(posedge clock) disable iff (reset)
      (state_ff == vbc_pkg::ST_LOAD) |-> !rd_valid_ff)
      else $error("read pipeline busy while loading voxels");

   a_done_waits : assert property (@(posedge clock) disable iff (reset)
      (reduce_done && !cfg_clear) |=> (state_ff == vbc_pkg::ST_WAIT))
      else $error("reduction finished without waiting for results");

   a_level_range : assert property (@(posedge clock) disable iff (reset)
      (state_ff == vbc_pkg::ST_REDUCE) |->
         (level_ff != '0 && level_ff <= geom.pad_exp))
      else $error("reduction level out of range");

   a_box_written : assert property (@(posedge clock) disable iff (reset || cfg_clear)
      (rd_valid_ff && rd_last_ff) |-> st_wr_en)
      else $error("merged box not written back");

endmodule

`default_nettype wire

FILE: tb/voxel_box_counting_core_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for voxel_box_counting_core: a directed plan, then random volumes.
// Each box count is checked against a predictor that tracks occupied boxes per level.
// Depends on vbc_pkg and voxel_box_counting_core.

module voxel_box_counting_core_test;
   import vbc_pkg::*;

   localparam int CLOCK_HALF    = 5;
   localparam int SETTLE_CYCLES = 16;
   localparam int DRAIN_CYCLES  = 64;
   localparam int HOLD_CYCLES   = 600;
   localparam int PART_ITEMS    = 80;
   localparam int REPORT_MAX    = 10;
   localparam int VOLUME_CAP    = 96;
   localparam int BOX_SLOTS     = LEVELS * DEPTH;
   localparam int PLAN_LEN      = 22;

   localparam logic [LABEL_W-1:0] LABEL_PORE    = 2'd0;
   localparam logic [LABEL_W-1:0] LABEL_SURFACE = 2'd1;
   localparam logic [LABEL_W-1:0] LABEL_BULK    = 2'd2;
   localparam logic [IDX_W-1:0]   REG_SPARE     = 2'd3;

   typedef enum logic {ROW_VOXEL, ROW_WRITE} row_kind_type;
   typedef enum int unsigned {MIX_ANY, MIX_ONE, MIX_SPARSE, MIX_SOLID} label_mix_type;

   typedef struct packed {
      row_kind_type      kind;
      logic [IDX_W-1:0]  index;   // register of a write
      logic [DIM_W-1:0]  value;   // label of a voxel, data of a write
      logic              pinned;  // counts of a single-voxel cube given by hits
      logic [PHASES-1:0] hits;
   } plan_row_type;

   typedef struct packed {
      logic [PHASE_W-1:0] phase;
      logic [EXP_W-1:0]   scale;
      logic [COUNT_W-1:0] boxes;
      logic               last;
   } box_count_type;

   // Single-voxel cubes first, then a 3x1x1 volume, then a 2x2x1 volume that is
   // interrupted by a write to the unused index, dropped by a real write and then sent in full.
   localparam plan_row_type PLAN [PLAN_LEN] = '{
      '{ROW_WRITE, REG_ROWS,    7'd0, 1'b0, 3'b000},
      '{ROW_WRITE, REG_COLUMNS, 7'd1, 1'b0, 3'b000},
      '{ROW_WRITE, REG_SLICES,  7'd1, 1'b0, 3'b000},
      '{ROW_VOXEL, '0, DIM_W'(LABEL_PORE),    1'b1, 3'b001},
      '{ROW_VOXEL, '0, DIM_W'(LABEL_SURFACE), 1'b1, 3'b010},
      '{ROW_VOXEL, '0, DIM_W'(LABEL_BULK),    1'b1, 3'b100},
      '{ROW_VOXEL, '0, DIM_W'(LABEL_NONE),    1'b1, 3'b000},
      '{ROW_WRITE, REG_ROWS,    7'd3, 1'b0, 3'b000},
      '{ROW_VOXEL, '0, DIM_W'(LABEL_BULK),    1'b0, 3'b000},
      '{ROW_VOXEL, '0, DIM_W'(LABEL_NONE),    1'b0, 3'b000},
      '{ROW_VOXEL, '0, DIM_W'(LABEL_PORE),    1'b0, 3'b000},
      '{ROW_WRITE, REG_COLUMNS, 7'd2, 1'b0, 3'b000},
      '{ROW_WRITE, REG_ROWS,    7'd2, 1'b0, 3'b000},
      '{ROW_VOXEL, '0, DIM_W'(LABEL_SURFACE), 1'b0, 3'b000},
      '{ROW_VOXEL, '0, DIM_W'(LABEL_BULK),    1'b0, 3'b000},
      '{ROW_WRITE, REG_SPARE,   7'd127, 1'b0, 3'b000},
      '{ROW_VOXEL, '0, DIM_W'(LABEL_PORE),    1'b0, 3'b000},
      '{ROW_WRITE, REG_COLUMNS, 7'd2, 1'b0, 3'b000},
      '{ROW_VOXEL, '0, DIM_W'(LABEL_NONE),    1'b0, 3'b000},
      '{ROW_VOXEL, '0, DIM_W'(LABEL_NONE),    1'b0, 3'b000},
      '{ROW_VOXEL, '0, DIM_W'(LABEL_NONE),    1'b0, 3'b000},
      '{ROW_VOXEL, '0, DIM_W'(LABEL_SURFACE), 1'b0, 3'b000}
   };

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;
   logic                  rsp_tlast;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [IDX_W-1:0]      csr_index = REG_ROWS;
   logic [DIM_W-1:0]      csr_data = '0;

   // predictor state
   logic [DIM_W-1:0] set_rows = DIM_W'(SIDE_MAX);
   logic [DIM_W-1:0] set_columns = DIM_W'(SIDE_MAX);
   logic [DIM_W-1:0] set_slices = DIM_W'(SIDE_MAX);
   int unsigned      voxel_pos = 0;
   bit [PHASES-1:0]  box_seen [BOX_SLOTS];
   int unsigned      touched_slots [$];
   int unsigned      box_tally [PHASES][LEVELS];
   box_count_type    pending_counts [$];

   int unsigned mismatches = 0;
   int unsigned voxels_sent = 0;
   int unsigned sender_idle_pct = 0;
   int unsigned receiver_idle_pct = 0;
   bit          hold_wanted = 1'b0;
   bit          hold_done = 1'b0;
   int unsigned hold_left = 0;

   voxel_box_counting_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #(CLOCK_HALF) clock = ~clock;

   function automatic int unsigned used_side(input logic [DIM_W-1:0] v);
      if (v == '0) return 1;
      if (v > DIM_W'(SIDE_MAX)) return SIDE_MAX;
      return v;
   endfunction

   function automatic int unsigned cube_exp();
      int unsigned widest;
      int unsigned e;
      widest = used_side(set_rows);
      if (used_side(set_columns) > widest) widest = used_side(set_columns);
      if (used_side(set_slices) > widest) widest = used_side(set_slices);
      e = 0;
      while ((1 << e) < widest) e++;
      return e;
   endfunction

   function automatic void forget_volume();
      foreach (touched_slots[n]) box_seen[touched_slots[n]] = '0;
      touched_slots.delete();
      foreach (box_tally[p, e]) box_tally[p][e] = 0;
      voxel_pos = 0;
   endfunction

   function automatic void take_dimension(input logic [IDX_W-1:0] index,
                                          input logic [DIM_W-1:0] data);
      if (index == REG_SPARE) return;
      case (index)
         REG_ROWS: set_rows = data;
         REG_COLUMNS: set_columns = data;
         default: set_slices = data;
      endcase
      forget_volume();
   endfunction

   // Mark the voxel's box at every level; the last voxel of the volume releases the counts.
   function automatic void tally_voxel(input logic [LABEL_W-1:0] label, input bit publish);
      int unsigned   rows, cols, total, top, i, j, k, e, ph, slot;
      box_count_type r;
      rows  = used_side(set_rows);
      cols  = used_side(set_columns);
      total = rows * cols * used_side(set_slices);
      top   = cube_exp();
      if (voxel_pos >= total) voxel_pos = 0;
      i = voxel_pos % rows;
      j = (voxel_pos / rows) % cols;
      k = voxel_pos / (rows * cols);
      if (label != LABEL_NONE) begin
         for (e = 0; e <= top; e++) begin
            slot = e * DEPTH + (((k >> e) << (2 * COORD_W)) | ((j >> e) << COORD_W) | (i >> e));
            if (box_seen[slot] == '0) touched_slots.push_back(slot);
            if (!box_seen[slot][label]) begin
               box_seen[slot][label] = 1'b1;
               box_tally[label][e]++;
            end
         end
      end
      voxel_pos++;
      if (voxel_pos < total) return;
      if (publish) begin
         for (ph = 0; ph < PHASES; ph++) begin
            for (e = 0; e <= top; e++) begin
               r.phase = PHASE_W'(ph);
               r.scale = EXP_W'(e);
               r.boxes = COUNT_W'(box_tally[ph][e]);
               r.last  = (ph == PHASES - 1) && (e == top);
               pending_counts.push_back(r);
            end
         end
      end
      forget_volume();
   endfunction

   task automatic offer_voxel(input logic [LABEL_W-1:0] label, input bit pinned,
                              input logic [PHASES-1:0] hits);
      int unsigned   ph;
      box_count_type r;
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_DATA_W'(label);
      do @(posedge clock); while (!req_tready);
      tally_voxel(label, !pinned);
      if (pinned) begin
         for (ph = 0; ph < PHASES; ph++) begin
            r.phase = PHASE_W'(ph);
            r.scale = '0;
            r.boxes = COUNT_W'(hits[ph]);
            r.last  = (PHASE_W'(ph) == PHASE_BULK);
            pending_counts.push_back(r);
         end
      end
      voxels_sent++;
      @(negedge clock);
   endtask

   // Write only once every count has come back and the block has settled.
   task automatic write_reg(input logic [IDX_W-1:0] index, input logic [DIM_W-1:0] data);
      req_tvalid <= 1'b0;
      while (pending_counts.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      take_dimension(index, data);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_dims(input logic [DIM_W-1:0] rows, input logic [DIM_W-1:0] cols,
                           input logic [DIM_W-1:0] slices);
      write_reg(REG_ROWS, rows);
      write_reg(REG_COLUMNS, cols);
      write_reg(REG_SLICES, slices);
   endtask

   task automatic send_volume(input int unsigned count);
      label_mix_type      mix;
      logic [LABEL_W-1:0] main_label;
      logic [LABEL_W-1:0] label;
      int unsigned        n;
      mix = label_mix_type'($urandom_range(0, 3));
      main_label = LABEL_W'($urandom_range(0, 3));
      for (n = 0; n < count; n++) begin
         case (mix)
            MIX_ANY: label = LABEL_W'($urandom_range(0, 3));
            MIX_ONE: label = ($urandom_range(0, 9) == 0) ? LABEL_W'($urandom_range(0, 3))
                                                        : main_label;
            MIX_SPARSE: label = ($urandom_range(0, 7) == 0) ? LABEL_W'($urandom_range(0, 2))
                                                           : LABEL_NONE;
            default: label = LABEL_W'($urandom_range(0, 2));
         endcase
         offer_voxel(label, 1'b0, '0);
      end
   endtask

   function automatic logic [DIM_W-1:0] pick_side();
      int unsigned roll;
      roll = $urandom_range(0, 9);
      if (roll == 0) return '0;
      if (roll <= 7) return DIM_W'($urandom_range(1, 4));
      return DIM_W'($urandom_range(5, 12));
   endfunction

   function automatic void flag_error(input string what, input box_count_type want,
                                      input int unsigned expected, input int unsigned actual);
      mismatches++;
      if (mismatches <= REPORT_MAX)
         $display("%0t: %s mismatch (phase %0d, scale %0d): expected %0d, got %0d",
                  $time, what, want.phase, want.scale, expected, actual);
   endfunction

   // Receiver: random stalls, plus one long hold-off once a result is waiting.
   always @(negedge clock) begin
      if (hold_wanted && !hold_done && rsp_tvalid) begin
         hold_left = HOLD_CYCLES;
         hold_done = 1'b1;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= receiver_idle_pct);
      end
   end

   always @(posedge clock) begin : check_counts
      box_count_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_counts.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
               $display("%0t: unexpected result: phase %0d, scale %0d, count %0d, last %0d",
                        $time, rsp_tuser[PHASE_W-1:0], rsp_tuser[PHASE_W +: EXP_W],
                        rsp_tdata[COUNT_W-1:0], rsp_tlast);
         end else begin
            want = pending_counts.pop_front();
            if (rsp_tuser[PHASE_W-1:0] !== want.phase)
               flag_error("phase", want, want.phase, rsp_tuser[PHASE_W-1:0]);
            if (rsp_tuser[PHASE_W +: EXP_W] !== want.scale)
               flag_error("scale_exponent", want, want.scale, rsp_tuser[PHASE_W +: EXP_W]);
            if (rsp_tdata[COUNT_W-1:0] !== want.boxes)
               flag_error("box_count", want, want.boxes, rsp_tdata[COUNT_W-1:0]);
            if (rsp_tlast !== want.last)
               flag_error("last_result", want, want.last, rsp_tlast);
         end
      end
   end

   initial begin : stimulus
      int unsigned        n, part, part_start, volume, cut, big_reg, pick;
      logic [DIM_W-1:0]   rows, cols, slices, big_side;
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      sender_idle_pct   = 19;
      receiver_idle_pct = 69;

      for (n = 0; n < PLAN_LEN; n++) begin
         if (PLAN[n].kind == ROW_WRITE)
            write_reg(PLAN[n].index, PLAN[n].value);
         else
            offer_voxel(PLAN[n].value[LABEL_W-1:0], PLAN[n].pinned, PLAN[n].hits);
      end

      // One volume with the largest side, on a random axis; the rest stay at one.
      big_reg  = $urandom_range(0, 2);
      big_side = $urandom_range(0, 1) ? 7'd127 : DIM_W'(SIDE_MAX);
      set_dims((big_reg == 0) ? big_side : DIM_W'($urandom_range(0, 1)),
               (big_reg == 1) ? big_side : DIM_W'($urandom_range(0, 1)),
               (big_reg == 2) ? big_side : DIM_W'($urandom_range(0, 1)));
      send_volume(SIDE_MAX);

      for (part = 0; part < 3; part++) begin
         sender_idle_pct   = (part == 0) ? 19 : (part == 1) ? 69 : 0;
         receiver_idle_pct = (part == 0) ? 69 : (part == 1) ? 19 : 0;
         part_start = voxels_sent;
         if (part == 2) begin
            // hold off the first results while the next volume is already offered
            set_dims(DIM_W'(2), DIM_W'(2), DIM_W'(1));
            hold_wanted = 1'b1;
            send_volume(4);
            send_volume(4);
         end
         while (voxels_sent - part_start < PART_ITEMS) begin
            rows   = pick_side();
            cols   = pick_side();
            slices = pick_side();
            if (used_side(rows) * used_side(cols) * used_side(slices) > VOLUME_CAP) begin
               cols   = DIM_W'($urandom_range(1, 4));
               slices = DIM_W'($urandom_range(0, 1));
            end
            set_dims(rows, cols, slices);
            volume = used_side(rows) * used_side(cols) * used_side(slices);
            repeat ($urandom_range(1, 3)) begin
               if ($urandom_range(0, 7) == 0) begin
                  // interrupt the volume: the spare index keeps it, a real write drops it
                  cut = $urandom_range(1, volume) - 1;
                  send_volume(cut);
                  if ($urandom_range(0, 1)) begin
                     write_reg(REG_SPARE, DIM_W'($urandom_range(0, 127)));
                     send_volume(volume - cut);
                  end else begin
                     pick = $urandom_range(0, 2);
                     if (pick == 0) write_reg(REG_ROWS, rows);
                     else if (pick == 1) write_reg(REG_COLUMNS, cols);
                     else write_reg(REG_SLICES, slices);
                  end
               end else begin
                  send_volume(volume);
               end
            end
         end
      end

      req_tvalid <= 1'b0;
      while (pending_counts.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatches == 0) begin
         $display("voxel_box_counting_core_test: clean");
      end else begin
         $display("voxel_box_counting_core_test: errors");
      end
      $finish;
   end

   initial begin : watchdog
      #20_000_000;
      $display("voxel_box_counting_core_test: errors");
      $finish;
   end

endmodule

FILE: sim.f
hw/rtl/vbc_pkg.sv
hw/rtl/vbc_store.sv
hw/rtl/vbc_walker.sv
hw/rtl/voxel_box_counting_core.sv
tb/voxel_box_counting_core_test.sv
